// ===== rtl/dpb_pkg.sv =====
// dpb_pkg: types, constants and helper functions of the depth pixel back-projection block
// used by every rtl file of the block; depends on nothing
`default_nettype none

package dpb_pkg;

    // image geometry
    localparam int MAX_WIDTH   = 4096;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = 12;
    localparam int IMG_WIDTH_W = 13;

    // offset from the principal point, Q.4 pixels, magnitude only
    localparam int POS_W = (COL_W + 4 > 16) ? COL_W + 4 : 16;

    // shared multiplier: a operand holds |offset| * z, b operand holds a 24 bit factor
    localparam int MB_W   = 24;
    localparam int MA_W   = POS_W + 16;
    localparam int PROD_W = MA_W + MB_W;

    // Q.4 * Q8.8 * Q0.24 = Q.36, result is Q.8
    localparam int FRAC_SHIFT = 28;
    localparam int MAG_W      = PROD_W - FRAC_SHIFT + 1;

    // sampling: keep when lfsr mod KEEP_MODULUS is zero, by reciprocal multiply
    localparam int KEEP_MODULUS = 10;
    localparam int KEEP_SHIFT   = 16 + $clog2(KEEP_MODULUS);
    localparam int KEEP_RECIP_W = 17;
    localparam longint KEEP_RECIP_VAL =
        ((64'd1 << KEEP_SHIFT) + KEEP_MODULUS - 1) / KEEP_MODULUS;
    localparam logic [KEEP_RECIP_W-1:0] KEEP_RECIP = KEEP_RECIP_W'(KEEP_RECIP_VAL);

    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_SCALE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_SEED = 3'd6;

    localparam logic [IMG_WIDTH_W-1:0] RST_IMAGE_WIDTH = 13'd640;
    localparam logic [15:0]            RST_CENTER_X    = 16'd5120;
    localparam logic [15:0]            RST_CENTER_Y    = 16'd3840;
    localparam logic [MB_W-1:0]        RST_INV_FOCAL_X = 24'd32263;
    localparam logic [MB_W-1:0]        RST_INV_FOCAL_Y = 24'd32263;
    localparam logic [15:0]            RST_DEPTH_SCALE = 16'd28494;
    localparam logic [15:0]            RST_SAMPLE_SEED = 16'd44257;

    typedef struct packed {
        logic [15:0] depth_raw;
        logic        start_of_frame;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [15:0]        point_z;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_Z,
        ST_CHECK_Z,
        ST_MUL_X1,
        ST_MUL_X2,
        ST_MUL_Y1,
        ST_MUL_Y2,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        MUL_DEPTH,
        MUL_DX,
        MUL_DY,
        MUL_INVX,
        MUL_INVY
    } mul_op_t;

    typedef struct packed {
        logic    take;
        logic    mul_en;
        mul_op_t mul_op;
        logic    load_z;
        logic    load_x;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        logic keep;
        logic z_zero;
    } status_t;

    // galois lfsr, shift right, taps applied when a one drops out
    function automatic logic [15:0] lfsr_step(logic [15:0] s);
        logic [15:0] n;
        n = {1'b0, s[15:1]};
        if (s[0]) begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

    // round half away from zero, then apply sign; magnitude stays far below 2^31
    function automatic logic signed [31:0] round_point(logic [PROD_W-1:0] prod, logic neg);
        logic [PROD_W:0]  sum;
        logic [MAG_W-1:0] mag;
        logic [31:0]      m32;
        sum = {1'b0, prod} + ((PROD_W + 1)'(1) << (FRAC_SHIFT - 1));
        mag = sum[PROD_W:FRAC_SHIFT];
        m32 = 32'(mag);
        return neg ? signed'(32'd0 - m32) : signed'(m32);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dpb_ctrl.sv =====
// dpb_ctrl: sequencing state machine of the back-projection block
// depends on dpb_pkg; drives the datapath through cmd_t and reads status_t
`default_nettype none

module dpb_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             out_free,
    input  wire dpb_pkg::status_t status,
    output dpb_pkg::cmd_t         cmd
);

    dpb_pkg::state_t state_reg;
    dpb_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dpb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.mul_op   = dpb_pkg::MUL_DEPTH;
        case (state_reg)
            dpb_pkg::ST_IDLE: begin
                // no transaction is taken while reset is held
                s_ready  = aresetn;
                cmd.take = s_valid && aresetn;
                if (s_valid && aresetn && status.keep) begin
                    state_next = dpb_pkg::ST_MUL_Z;
                end
            end
            dpb_pkg::ST_MUL_Z: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = dpb_pkg::MUL_DEPTH;
                state_next = dpb_pkg::ST_CHECK_Z;
            end
            dpb_pkg::ST_CHECK_Z: begin
                cmd.load_z = 1'b1;
                state_next = status.z_zero ? dpb_pkg::ST_IDLE : dpb_pkg::ST_MUL_X1;
            end
            dpb_pkg::ST_MUL_X1: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = dpb_pkg::MUL_DX;
                state_next = dpb_pkg::ST_MUL_X2;
            end
            dpb_pkg::ST_MUL_X2: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = dpb_pkg::MUL_INVX;
                state_next = dpb_pkg::ST_MUL_Y1;
            end
            dpb_pkg::ST_MUL_Y1: begin
                cmd.load_x = 1'b1;
                cmd.mul_en = 1'b1;
                cmd.mul_op = dpb_pkg::MUL_DY;
                state_next = dpb_pkg::ST_MUL_Y2;
            end
            dpb_pkg::ST_MUL_Y2: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = dpb_pkg::MUL_INVY;
                state_next = dpb_pkg::ST_DONE;
            end
            dpb_pkg::ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = dpb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dpb_pkg::ST_IDLE;
            end
        endcase
    end

    // a pixel lost to sampling frees the block at once
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.take && !status.keep) |=> (state_reg == dpb_pkg::ST_IDLE))
        else $error("dropped pixel did not return to idle");

    // zero depth ends the item without touching the multiplier again
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dpb_pkg::ST_CHECK_Z && status.z_zero) |=> !cmd.mul_en)
        else $error("zero depth item kept running");

endmodule

`default_nettype wire

// ===== rtl/dpb_datapath.sv =====
// dpb_datapath: config registers, pixel counters, lfsr sampler, shared multiplier
// depends on dpb_pkg; steered by dpb_ctrl through cmd_t
`default_nettype none

module dpb_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [dpb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dpb_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  wire dpb_pkg::in_item_t                 s_item,
    input  wire dpb_pkg::cmd_t                     cmd,
    output dpb_pkg::status_t                       status,
    output dpb_pkg::out_item_t                     result
);

    // configuration
    logic [dpb_pkg::IMG_WIDTH_W-1:0] img_width_reg;
    logic [15:0]                     center_x_reg;
    logic [15:0]                     center_y_reg;
    logic [dpb_pkg::MB_W-1:0]        inv_fx_reg;
    logic [dpb_pkg::MB_W-1:0]        inv_fy_reg;
    logic [15:0]                     scale_reg;
    logic [15:0]                     seed_reg;

    // pixel position and sampler state
    logic [dpb_pkg::COL_W-1:0] col_reg, col_next;
    logic [dpb_pkg::ROW_W-1:0] row_reg, row_next;
    logic [15:0]               lfsr_reg, lfsr_next;

    // per item working registers
    logic [15:0]                depth_reg;
    logic [dpb_pkg::POS_W-1:0]  dx_abs_reg, dx_abs_next;
    logic                       dx_neg_reg, dx_neg_next;
    logic [dpb_pkg::POS_W-1:0]  dy_abs_reg, dy_abs_next;
    logic                       dy_neg_reg, dy_neg_next;
    logic [15:0]                z_reg, z_next;
    logic [dpb_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [31:0]         x_reg;

    logic [dpb_pkg::COL_W:0]   width_eff;
    logic [dpb_pkg::COL_W-1:0] u;
    logic [dpb_pkg::ROW_W-1:0] v;
    logic [dpb_pkg::COL_W:0]   col_inc;
    logic [15:0]               lfsr_base;
    logic [15:0]               lfsr_stepped;
    logic [15:0]               keep_q;
    logic [15+dpb_pkg::KEEP_RECIP_W:0] keep_prod;
    logic                      keep_hit;
    logic [dpb_pkg::POS_W:0]   pos_x, pos_y, cen_x, cen_y, diff_x, diff_y;
    logic [dpb_pkg::MA_W-1:0]  mul_a;
    logic [dpb_pkg::MB_W-1:0]  mul_b;
    logic [32:0]               z_sum;
    logic                      z_is_zero;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_width_reg <= dpb_pkg::RST_IMAGE_WIDTH;
            center_x_reg  <= dpb_pkg::RST_CENTER_X;
            center_y_reg  <= dpb_pkg::RST_CENTER_Y;
            inv_fx_reg    <= dpb_pkg::RST_INV_FOCAL_X;
            inv_fy_reg    <= dpb_pkg::RST_INV_FOCAL_Y;
            scale_reg     <= dpb_pkg::RST_DEPTH_SCALE;
            seed_reg      <= dpb_pkg::RST_SAMPLE_SEED;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dpb_pkg::CFG_IMAGE_WIDTH: img_width_reg <= cfg_wr_data[dpb_pkg::IMG_WIDTH_W-1:0];
                dpb_pkg::CFG_CENTER_X:    center_x_reg  <= cfg_wr_data[15:0];
                dpb_pkg::CFG_CENTER_Y:    center_y_reg  <= cfg_wr_data[15:0];
                dpb_pkg::CFG_INV_FOCAL_X: inv_fx_reg    <= cfg_wr_data;
                dpb_pkg::CFG_INV_FOCAL_Y: inv_fy_reg    <= cfg_wr_data;
                dpb_pkg::CFG_DEPTH_SCALE: scale_reg     <= cfg_wr_data[15:0];
                dpb_pkg::CFG_SAMPLE_SEED: seed_reg      <= cfg_wr_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // width clamped to 1..MAX_WIDTH
    always_comb begin
        if (img_width_reg == '0) begin
            width_eff = (dpb_pkg::COL_W + 1)'(1);
        end else if (32'(img_width_reg) > 32'(dpb_pkg::MAX_WIDTH)) begin
            width_eff = (dpb_pkg::COL_W + 1)'(dpb_pkg::MAX_WIDTH);
        end else begin
            width_eff = (dpb_pkg::COL_W + 1)'(img_width_reg);
        end
    end

    // position, counter advance and sampling decision for the offered pixel
    always_comb begin
        u = s_item.start_of_frame ? '0 : col_reg;
        v = s_item.start_of_frame ? '0 : row_reg;
        if ({1'b0, u} >= width_eff) begin
            u = '0;
        end
        col_inc = {1'b0, u} + (dpb_pkg::COL_W + 1)'(1);
        if (col_inc >= width_eff) begin
            col_next = '0;
            row_next = v + dpb_pkg::ROW_W'(1);
        end else begin
            col_next = col_inc[dpb_pkg::COL_W-1:0];
            row_next = v;
        end

        if (s_item.start_of_frame) begin
            lfsr_base = (seed_reg == '0) ? 16'd1 : seed_reg;
        end else begin
            lfsr_base = lfsr_reg;
        end
        lfsr_stepped = dpb_pkg::lfsr_step(lfsr_base);
        lfsr_next    = lfsr_stepped;

        keep_prod = (16 + dpb_pkg::KEEP_RECIP_W)'(lfsr_stepped)
                    * (16 + dpb_pkg::KEEP_RECIP_W)'(dpb_pkg::KEEP_RECIP);
        keep_q    = 16'(keep_prod >> dpb_pkg::KEEP_SHIFT);
        keep_hit  = ((32'(keep_q) * 32'(dpb_pkg::KEEP_MODULUS)) == 32'(lfsr_stepped));

        pos_x  = (dpb_pkg::POS_W + 1)'({u, 4'b0000});
        pos_y  = (dpb_pkg::POS_W + 1)'({v, 4'b0000});
        cen_x  = (dpb_pkg::POS_W + 1)'(center_x_reg);
        cen_y  = (dpb_pkg::POS_W + 1)'(center_y_reg);
        diff_x = pos_x - cen_x;
        diff_y = pos_y - cen_y;
        dx_neg_next = diff_x[dpb_pkg::POS_W];
        dy_neg_next = diff_y[dpb_pkg::POS_W];
        dx_abs_next = dx_neg_next ? dpb_pkg::POS_W'(cen_x - pos_x) : dpb_pkg::POS_W'(diff_x);
        dy_abs_next = dy_neg_next ? dpb_pkg::POS_W'(cen_y - pos_y) : dpb_pkg::POS_W'(diff_y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            lfsr_reg <= 16'd1;
        end else if (cmd.take) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            lfsr_reg <= lfsr_next;
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (cmd.mul_op)
            dpb_pkg::MUL_DEPTH: begin
                mul_a = dpb_pkg::MA_W'(depth_reg);
                mul_b = dpb_pkg::MB_W'(scale_reg);
            end
            dpb_pkg::MUL_DX: begin
                mul_a = dpb_pkg::MA_W'(dx_abs_reg);
                mul_b = dpb_pkg::MB_W'(z_reg);
            end
            dpb_pkg::MUL_DY: begin
                mul_a = dpb_pkg::MA_W'(dy_abs_reg);
                mul_b = dpb_pkg::MB_W'(z_reg);
            end
            dpb_pkg::MUL_INVX: begin
                mul_a = prod_reg[dpb_pkg::MA_W-1:0];
                mul_b = inv_fx_reg;
            end
            dpb_pkg::MUL_INVY: begin
                mul_a = prod_reg[dpb_pkg::MA_W-1:0];
                mul_b = inv_fy_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = dpb_pkg::PROD_W'(mul_a) * dpb_pkg::PROD_W'(mul_b);
    end

    // z = round half up of depth * scale / 2^16
    always_comb begin
        z_sum     = {1'b0, prod_reg[31:0]} + 33'h0_0000_8000;
        z_next    = z_sum[31:16];
        z_is_zero = (z_next == '0);
    end

    always_comb begin
        status.keep   = keep_hit;
        status.z_zero = z_is_zero;
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            depth_reg  <= s_item.depth_raw;
            dx_abs_reg <= dx_abs_next;
            dx_neg_reg <= dx_neg_next;
            dy_abs_reg <= dy_abs_next;
            dy_neg_reg <= dy_neg_next;
        end
        if (cmd.mul_en) begin
            prod_reg <= prod_next;
        end
        if (cmd.load_z) begin
            z_reg <= z_next;
        end
        if (cmd.load_x) begin
            x_reg <= dpb_pkg::round_point(prod_reg, dx_neg_reg);
        end
    end

    assign result.point_x = x_reg;
    assign result.point_y = dpb_pkg::round_point(prod_reg, dy_neg_reg);
    assign result.point_z = z_reg;

    // column counter never leaves the row it was sized for
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |=> ({1'b0, col_reg} < $past(width_eff)))
        else $error("column counter beyond image width");

    // lfsr never locks at zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |=> (lfsr_reg != '0))
        else $error("sampling lfsr reached zero");

endmodule

`default_nettype wire

// ===== rtl/depth_pixel_backprojection.sv =====
// depth_pixel_backprojection: top level, controller + datapath + output register
// depends on dpb_pkg, dpb_ctrl and dpb_datapath
//
//  channel   direction  handshake              payload
//  s_        in         s_valid / s_ready      s_item  (depth_raw, start_of_frame)
//  m_        out        m_valid / m_ready      m_point (point_x, point_y, point_z)
//  cfg_      in         cfg_wr_en (no wait)    cfg_index, cfg_wr_data
//
//  a pixel lost to sampling returns the block to idle at once, a sampled pixel of zero
//  depth ends after the depth check: one shared 32x24 multiplier runs depth*scale, then
//  for a kept pixel |du|*z, *1/fx, |dv|*z, *1/fy back to back, one product a cycle
//  reset (aresetn low at a clock edge) loads default calibration, clears the
//  counters and sets the lfsr to 1; no clearing pass
//  the output register holds one finished point; the next pixel is taken while it
//  waits, and a second point waits in the last step until the register frees up
`default_nettype none

module depth_pixel_backprojection (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    // pixel input
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire dpb_pkg::in_item_t              s_item,

    // point output
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output dpb_pkg::out_item_t                  m_point,

    // configuration writes
    input  wire logic                           cfg_wr_en,
    input  wire logic [dpb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dpb_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

    dpb_pkg::cmd_t      cmd;
    dpb_pkg::status_t   status;
    dpb_pkg::out_item_t result;

    // output register
    logic               m_valid_reg;
    logic               m_valid_next;
    dpb_pkg::out_item_t m_point_reg;
    logic               out_free;

    // register can take a point when empty or when its point leaves this cycle
    assign out_free = !m_valid_reg || m_ready;

    dpb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    dpb_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_item      (s_item),
        .cmd         (cmd),
        .status      (status),
        .result      (result)
    );

    // valid set on load, cleared once the transaction completes
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_point_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_point = m_point_reg;

    // a waiting point is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten while full");

endmodule

`default_nettype wire
